@@ sv/srgb_lab_pkg.sv @@
`default_nettype none

package srgb_lab_pkg;

  // Fixed-point formats
  localparam int unsigned FRAC_BITS = 8;    // fraction bits of L*, a*, b*
  localparam int unsigned LIN_BITS  = 20;   // linear light and f() in Q20
  localparam int unsigned WORK_BITS = 30;   // gamma table build precision

  localparam int unsigned GAMMA_W = LIN_BITS + 1;        // 0 .. 1.0 in Q20
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned PROD_W  = GAMMA_W + COEF_W;    // matrix product
  localparam int unsigned SUM_W   = 44;                  // matrix row sum
  localparam int unsigned RATIO_W = LIN_BITS + 1;        // xr/yr/zr and f()

  // Division by the reference white: reciprocal estimate plus one correction
  localparam int unsigned PRE_SHIFT   = 20;
  localparam int unsigned RECIP_SHIFT = 46;
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned EST_IN_W    = SUM_W - PRE_SHIFT;
  localparam int unsigned EST_PROD_W  = EST_IN_W + RECIP_W;

  typedef logic [COEF_W-1:0]  coef_t;
  typedef logic [RECIP_W-1:0] recip_t;

  // Linear RGB to XYZ, scaled by 1e7; rows X, Y, Z; columns R, G, B
  localparam coef_t MAT_COEF [3][3] = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339,  24'd1191920, 24'd9503041}
  };

  // Reference white (D65) scaled by 1e7, its half for rounding, its reciprocal
  localparam coef_t WHITE_DIV [3] = '{24'd9504560, 24'd10000000, 24'd10887540};
  localparam coef_t WHITE_HALF [3] = '{24'd4752280, 24'd5000000, 24'd5443770};
  localparam recip_t WHITE_RECIP [3] = '{
    23'((64'd1 << RECIP_SHIFT) / 64'd9504560),
    23'((64'd1 << RECIP_SHIFT) / 64'd10000000),
    23'((64'd1 << RECIP_SHIFT) / 64'd10887540)
  };

  // Linear segment of f(): (kappa*v + 16)/116 in Q20, kappa = 903.3
  localparam int unsigned LIN_V_W     = 14;   // v at or below the limit fits
  localparam int unsigned LNUM_W      = 29;
  localparam int unsigned LIN_RECIP_W = 30;
  localparam int unsigned LIN_DIV_SH  = 40;
  localparam int unsigned LPROD_W     = LNUM_W + LIN_RECIP_W;
  localparam logic [63:0] LIN_LIMIT_W = (64'd8856 * 64'd1048576) / 64'd1000000;
  localparam logic [RATIO_W-1:0] LIN_LIMIT = LIN_LIMIT_W[RATIO_W-1:0];
  localparam logic [LNUM_W-1:0] LIN_SLOPE  = 29'd9033;
  localparam logic [LNUM_W-1:0] LIN_OFS    = 29'((64'd160 << LIN_BITS) + 64'd580);
  localparam logic [63:0] LIN_RECIP_FULL =
    ((64'd1 << LIN_DIV_SH) + 64'd1159) / 64'd1160;
  localparam logic [LIN_RECIP_W-1:0] LIN_RECIP = LIN_RECIP_FULL[LIN_RECIP_W-1:0];

  // Gamma decoding table, built at elaboration
  typedef logic [GAMMA_W-1:0] gamma_rom_t [256];

  function automatic logic [63:0] mulq30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << (WORK_BITS - 1))) >> WORK_BITS;
  endfunction

  function automatic logic [63:0] pow5q30(input logic [63:0] y);
    logic [63:0] y2, y4;
    y2 = mulq30(y, y);
    y4 = mulq30(y2, y2);
    return mulq30(y4, y);
  endfunction

  function automatic logic [GAMMA_W-1:0] decode_gamma(input logic [7:0] c);
    logic [63:0] cw, t, s, lo, hi, mid, lin;
    cw  = 64'(c);
    mid = '0;
    // linear toe of the sRGB curve
    if (cw <= 64'd10) begin
      return GAMMA_W'((cw * 64'd104857600 + 64'd164730) / 64'd329460);
    end
    // power 2.4 segment: t^2 * t^(2/5), fifth root by bisection
    t  = (((cw * 64'd1000 + 64'd14025) << WORK_BITS) + 64'd134512) / 64'd269025;
    s  = mulq30(t, t);
    lo = '0;
    hi = (64'd1 << WORK_BITS) + 64'd1;
    for (int i = 0; i < 32; i++) begin
      if (hi - lo > 64'd1) begin
        mid = lo + ((hi - lo) >> 1);
        if (pow5q30(mid) <= s) lo = mid;
        else hi = mid;
      end
    end
    lin = mulq30(s, lo);
    return GAMMA_W'((lin + (64'd1 << (WORK_BITS - LIN_BITS - 1))) >> (WORK_BITS - LIN_BITS));
  endfunction

  function automatic gamma_rom_t build_gamma_rom();
    gamma_rom_t rom;
    for (int c = 0; c < 256; c++) begin
      rom[c] = decode_gamma(8'(c));
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma_rom();

endpackage

`default_nettype wire

@@ sv/srgb_to_lab_pixel.sv @@
// sRGB to CIE L*a*b* (D65) pixel converter.
// Input channel: in_valid/in_ready with one pixel per item (in_blue, in_green,
// in_red bytes and in_end_of_row). Result channel: out_valid/out_ready with
// L* (unsigned), a* and b* (signed), all with 8 fraction bits, plus the
// end-of-row flag copied from the input.
// Throughput: one pixel per clock while in_ready is high. The depth is
// set by the 21-step bit-serial cube root, one step per stage, after six
// stages of gamma lookup, matrix and white division, and three stages of
// linear segment and final products; rounding and saturation feed the
// output register.
// Reset (rst_n low, synchronous) empties the pipeline and the output
// register; in_ready is high straight after.
// When the receiver stalls, the finished item waits in the output register;
// the pipeline keeps moving and taking items while it has a bubble at its
// end, and holds every stage otherwise, so nothing is lost or repeated.
// in_ready depends on out_ready combinationally.
`default_nettype none

module srgb_to_lab_pixel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_blue,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_red,
  input  logic               in_end_of_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        out_lightness,
  output logic signed [15:0] out_green_red,
  output logic signed [15:0] out_blue_yellow,
  output logic               out_end_of_row_out
);

  localparam int unsigned GAMMA_W    = srgb_lab_pkg::GAMMA_W;
  localparam int unsigned PROD_W     = srgb_lab_pkg::PROD_W;
  localparam int unsigned SUM_W      = srgb_lab_pkg::SUM_W;
  localparam int unsigned RATIO_W    = srgb_lab_pkg::RATIO_W;
  localparam int unsigned EST_PROD_W = srgb_lab_pkg::EST_PROD_W;
  localparam int unsigned PRE_SHIFT  = srgb_lab_pkg::PRE_SHIFT;
  localparam int unsigned LNUM_W     = srgb_lab_pkg::LNUM_W;
  localparam int unsigned LPROD_W    = srgb_lab_pkg::LPROD_W;
  localparam int unsigned LIN_V_W    = srgb_lab_pkg::LIN_V_W;
  localparam int unsigned LIN_BITS   = srgb_lab_pkg::LIN_BITS;
  localparam int unsigned FRAC_BITS  = srgb_lab_pkg::FRAC_BITS;

  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned CUBE_STEPS = RATIO_W;          // one root bit per step
  localparam int unsigned TGT_W      = 3 * CUBE_STEPS;   // v << 40, three bits a step
  localparam int unsigned CS_W       = 2 * RATIO_W;      // running root squared
  localparam int unsigned CR_W       = 48;               // cube root remainder
  localparam int unsigned PIPE_DEPTH = 6 + CUBE_STEPS + 3;

  // Output arithmetic
  localparam int unsigned OW  = 34;
  localparam int unsigned SH  = LIN_BITS - FRAC_BITS;
  localparam logic signed [OW-1:0] RND_HALF = OW'(1 << (SH - 1));
  localparam logic signed [OW-1:0] L_OFS    = OW'(16 << LIN_BITS);
  localparam logic signed [OW-1:0] L_MAX    = OW'(100 * (1 << FRAC_BITS));
  localparam logic signed [OW-1:0] A_MAX    = OW'(100 * (1 << FRAC_BITS));
  localparam logic signed [OW-1:0] A_MIN    = OW'(-100 * (1 << FRAC_BITS));
  localparam logic signed [OW-1:0] B_MAX    = OW'(100 * (1 << FRAC_BITS));
  localparam logic signed [OW-1:0] B_MIN    = OW'(-110 * (1 << FRAC_BITS));
  localparam logic signed [OW-1:0] K_L      = OW'(116);
  localparam logic signed [OW-1:0] K_A      = OW'(500);
  localparam logic signed [OW-1:0] K_B      = OW'(200);

  // ---------------------------------------------------------------------
  // Flow control: shift when the output can take an item or the last
  // stage holds a bubble
  // ---------------------------------------------------------------------
  logic                  out_valid_r;
  logic                  out_free;
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] eor_r;

  assign out_free = !out_valid_r || out_ready;
  assign adv      = out_free || !vld_r[PIPE_DEPTH-1];
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      eor_r <= {eor_r[PIPE_DEPTH-2:0], in_end_of_row};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: gamma decoding, columns R, G, B
  // ---------------------------------------------------------------------
  logic [GAMMA_W-1:0] lin_r [NUM_CH];

  always_ff @(posedge clk) begin
    if (adv) begin
      lin_r[0] <= srgb_lab_pkg::GAMMA_ROM[in_red];
      lin_r[1] <= srgb_lab_pkg::GAMMA_ROM[in_green];
      lin_r[2] <= srgb_lab_pkg::GAMMA_ROM[in_blue];
    end
  end

  // Per-lane registers (lanes X, Y, Z)
  logic [PROD_W-1:0]  prod_r  [NUM_CH][NUM_CH];
  logic [SUM_W-1:0]   num_r   [NUM_CH];
  logic [RATIO_W-1:0] qe4_r   [NUM_CH];
  logic [SUM_W-1:0]   num4_r  [NUM_CH];
  logic [PROD_W-1:0]  qd5_r   [NUM_CH];
  logic [RATIO_W-1:0] qe5_r   [NUM_CH];
  logic [SUM_W-1:0]   num5_r  [NUM_CH];
  logic [RATIO_W-1:0] v6_r    [NUM_CH];
  logic [RATIO_W-1:0] cy_r    [NUM_CH][CUBE_STEPS];
  logic [RATIO_W-1:0] cv_r    [NUM_CH][CUBE_STEPS];
  logic [CS_W-1:0]    cs_r    [NUM_CH][CUBE_STEPS-1];
  logic [CR_W-1:0]    crem_r  [NUM_CH][CUBE_STEPS-1];
  logic [LNUM_W-1:0]  lnum_r  [NUM_CH];
  logic               sel_r   [NUM_CH];
  logic [RATIO_W-1:0] yfin_r  [NUM_CH];
  logic [RATIO_W-1:0] f_r     [NUM_CH];

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane

    // Stage 2: matrix products
    for (genvar col = 0; col < NUM_CH; col++) begin : g_col
      always_ff @(posedge clk) begin
        if (adv) begin
          prod_r[ch][col] <= PROD_W'(lin_r[col]) *
                             PROD_W'(srgb_lab_pkg::MAT_COEF[ch][col]);
        end
      end
    end

    // Stage 3: row sum plus half the divisor
    logic [PROD_W+1:0] sum_nxt;
    assign sum_nxt = (PROD_W+2)'(prod_r[ch][0]) + (PROD_W+2)'(prod_r[ch][1]) +
                     (PROD_W+2)'(prod_r[ch][2]) +
                     (PROD_W+2)'(srgb_lab_pkg::WHITE_HALF[ch]);

    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[ch] <= sum_nxt[SUM_W-1:0];
      end
    end

    // Stage 4: quotient estimate from the reciprocal, at most one short
    logic [EST_PROD_W-1:0] est_nxt;
    assign est_nxt = EST_PROD_W'(num_r[ch][SUM_W-1:PRE_SHIFT]) *
                     EST_PROD_W'(srgb_lab_pkg::WHITE_RECIP[ch]);

    always_ff @(posedge clk) begin
      if (adv) begin
        qe4_r[ch]  <= est_nxt[EST_PROD_W-1 -: RATIO_W];
        num4_r[ch] <= num_r[ch];
      end
    end

    // Stage 5: estimate times divisor
    always_ff @(posedge clk) begin
      if (adv) begin
        qd5_r[ch]  <= PROD_W'(qe4_r[ch]) * PROD_W'(srgb_lab_pkg::WHITE_DIV[ch]);
        qe5_r[ch]  <= qe4_r[ch];
        num5_r[ch] <= num4_r[ch];
      end
    end

    // Stage 6: remainder check and correction
    logic [PROD_W-1:0] rem_nxt;
    logic              bump;
    assign rem_nxt = PROD_W'(num5_r[ch]) - qd5_r[ch];
    assign bump    = rem_nxt >= PROD_W'(srgb_lab_pkg::WHITE_DIV[ch]);

    always_ff @(posedge clk) begin
      if (adv) begin
        v6_r[ch] <= qe5_r[ch] + RATIO_W'(bump);
      end
    end

    // Cube root of v << 40, one root bit per stage
    for (genvar k = 0; k < CUBE_STEPS; k++) begin : g_step
      logic [RATIO_W-1:0] y_in;
      logic [RATIO_W-1:0] v_in;
      logic [CS_W-1:0]    s_in;
      logic [CR_W-1:0]    r_in;
      logic [TGT_W-1:0]   tgt;
      logic [CR_W-1:0]    r_sh;
      logic [CR_W-1:0]    trial;
      logic               take;

      if (k == 0) begin : g_first
        assign y_in = '0;
        assign s_in = '0;
        assign r_in = '0;
        assign v_in = v6_r[ch];
      end else begin : g_next
        assign y_in = cy_r[ch][k-1];
        assign s_in = cs_r[ch][k-1];
        assign r_in = crem_r[ch][k-1];
        assign v_in = cv_r[ch][k-1];
      end

      // trial = (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1
      assign tgt   = TGT_W'(v_in) << (2 * LIN_BITS);
      assign r_sh  = {r_in[CR_W-4:0], tgt[TGT_W-1-3*k -: 3]};
      assign trial = (CR_W'(s_in) << 3) + (CR_W'(s_in) << 2) +
                     (CR_W'(y_in) << 2) + (CR_W'(y_in) << 1) + CR_W'(1);
      assign take  = r_sh >= trial;

      always_ff @(posedge clk) begin
        if (adv) begin
          cy_r[ch][k] <= {y_in[RATIO_W-2:0], take};
          cv_r[ch][k] <= v_in;
        end
      end

      if (k < CUBE_STEPS - 1) begin : g_carry
        logic [CS_W-1:0] s_nxt;
        logic [CR_W-1:0] r_nxt;
        assign s_nxt = take ? (s_in << 2) + (CS_W'(y_in) << 2) + CS_W'(1) : (s_in << 2);
        assign r_nxt = take ? r_sh - trial : r_sh;

        always_ff @(posedge clk) begin
          if (adv) begin
            cs_r[ch][k]   <= s_nxt;
            crem_r[ch][k] <= r_nxt;
          end
        end
      end
    end

    // Linear segment numerator and segment select
    logic [RATIO_W-1:0] v_fin;
    logic [LNUM_W-1:0]  lnum_nxt;
    assign v_fin    = cv_r[ch][CUBE_STEPS-1];
    assign lnum_nxt = LNUM_W'(LNUM_W'(v_fin[LIN_V_W-1:0]) * srgb_lab_pkg::LIN_SLOPE) +
                      srgb_lab_pkg::LIN_OFS;

    always_ff @(posedge clk) begin
      if (adv) begin
        lnum_r[ch] <= lnum_nxt;
        sel_r[ch]  <= v_fin <= srgb_lab_pkg::LIN_LIMIT;
        yfin_r[ch] <= cy_r[ch][CUBE_STEPS-1];
      end
    end

    // Divide by 116 (1160 on the tenfold numerator) through the rounded-up reciprocal, then pick the segment
    logic [LPROD_W-1:0] lprod;
    assign lprod = LPROD_W'(lnum_r[ch]) * LPROD_W'(srgb_lab_pkg::LIN_RECIP);

    always_ff @(posedge clk) begin
      if (adv) begin
        f_r[ch] <= sel_r[ch] ?
                   RATIO_W'(lprod >> srgb_lab_pkg::LIN_DIV_SH) : yfin_r[ch];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Final products: 116 fy, 500 (fx - fy), 200 (fy - fz)
  // ---------------------------------------------------------------------
  logic signed [OW-1:0] fxs, fys, fzs;
  logic signed [OW-1:0] lmul_r, amul_r, bmul_r;

  assign fxs = $signed(OW'(f_r[0]));
  assign fys = $signed(OW'(f_r[1]));
  assign fzs = $signed(OW'(f_r[2]));

  always_ff @(posedge clk) begin
    if (adv) begin
      lmul_r <= fys * K_L;
      amul_r <= (fxs - fys) * K_A;
      bmul_r <= (fys - fzs) * K_B;
    end
  end

  // ---------------------------------------------------------------------
  // Round half up, saturate, load the output register
  // ---------------------------------------------------------------------
  logic signed [OW-1:0] lrnd, arnd, brnd;
  logic signed [OW-1:0] lclp, aclp, bclp;

  assign lrnd = (lmul_r - L_OFS + RND_HALF) >>> SH;
  assign arnd = (amul_r + RND_HALF) >>> SH;
  assign brnd = (bmul_r + RND_HALF) >>> SH;

  always_comb begin
    if (lrnd < 0) lclp = '0;
    else if (lrnd > L_MAX) lclp = L_MAX;
    else lclp = lrnd;

    if (arnd < A_MIN) aclp = A_MIN;
    else if (arnd > A_MAX) aclp = A_MAX;
    else aclp = arnd;

    if (brnd < B_MIN) bclp = B_MIN;
    else if (brnd > B_MAX) bclp = B_MAX;
    else bclp = brnd;
  end

  logic [14:0]        out_lightness_r;
  logic signed [15:0] out_green_red_r;
  logic signed [15:0] out_blue_yellow_r;
  logic               out_eor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_lightness_r   <= lclp[14:0];
      out_green_red_r   <= aclp[15:0];
      out_blue_yellow_r <= bclp[15:0];
      out_eor_r         <= eor_r[PIPE_DEPTH-1];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_lightness      = out_lightness_r;
  assign out_green_red      = out_green_red_r;
  assign out_blue_yellow    = out_blue_yellow_r;
  assign out_end_of_row_out = out_eor_r;

endmodule

`default_nettype wire
